// ===== hw/rtl/two_level_thread_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-level thread scheduler
// Immediate-implication and next-cycle checks on a clock with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_THREAD_SCHEDULER_DEFINES_SVH
`define TWO_LEVEL_THREAD_SCHEDULER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TLTS_ASSERT_SAME(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("scheduler check failed: same-cycle implication");

// Check that a condition implies another in the following cycle
`define TLTS_ASSERT_NEXT(label, clock, reset, cond, prop) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("scheduler check failed: next-cycle implication");

`endif

// ===== hw/rtl/tlts_pkg.sv =====
// ----------------------------------------------------------------------------
// tlts_pkg
// Shared types and constants of the two-level thread scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlts_pkg;

  // Default number of thread slots
  localparam int MAX_THREADS_DEF = 16;

  // Quantum length after reset
  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  // Command codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;
  localparam logic [1:0] OP_SET    = 2'd3;

  // One command
  typedef struct packed {
    logic [1:0] op;
    logic       priority_high;
  } in_t;

  // One result
  typedef struct packed {
    logic [3:0] running_thread;
    logic       running_is_high;
    logic [3:0] new_thread;
    logic       create_failed;
    logic       switched;
    logic       all_done;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/two_level_thread_scheduler.sv =====
// Sequencing: a command accepted in idle is latched, then worked out in the execute state,
// which registers the result and strobe. No new command is taken until the block is idle
//   again; busy is high in the execute state.
// Reset: synchronous, clears all control state; slot 0 runs, quantum is 10 ticks.
// The result is a one-cycle strobe and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// two_level_thread_scheduler
// Slot table with high and low FIFOs of thread ids in memory, round-robin quantum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_thread_scheduler_defines.svh"

module two_level_thread_scheduler #(
  parameter int MAX_THREADS = tlts_pkg::MAX_THREADS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire tlts_pkg::in_t  cmd,
  output logic                result_valid,
  output tlts_pkg::out_t      result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data
);

  localparam int TID_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Control registers
  logic [7:0]             quantum_length;
  logic [MAX_THREADS-1:0] slot_busy, slot_busy_next;
  logic [MAX_THREADS-1:0] slot_high, slot_high_next;
  logic [TID_W-1:0]       high_head, high_head_next, high_tail, high_tail_next;
  logic [TID_W-1:0]       low_head, low_head_next, low_tail, low_tail_next;
  logic [CNT_W-1:0]       high_count, high_count_next, low_count, low_count_next;
  logic [TID_W-1:0]       running_id, running_id_next;
  logic [7:0]             ticks_left, ticks_left_next;
  logic                   finished, finished_next;

  // Latched command
  tlts_pkg::in_t          cmd_q;

  // Queue memories and registered head reads
  logic [TID_W-1:0] high_mem [MAX_THREADS];
  logic [TID_W-1:0] low_mem  [MAX_THREADS];
  logic [TID_W-1:0] high_rd, low_rd;

  logic             high_we, low_we;
  logic [TID_W-1:0] high_wdata, low_wdata;

  // Free slot search
  logic             free_found;
  logic [TID_W-1:0] free_idx;

  // Result assembly
  tlts_pkg::out_t   res_next;
  logic [TID_W-1:0] new_id;
  logic             failed, sw;
  logic [7:0]       reload, ticks_dec;
  logic [TID_W+3:0] run_ext, new_ext;

  function automatic logic [TID_W-1:0] wrap_inc(input logic [TID_W-1:0] p);
    return (p == TID_W'(MAX_THREADS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign reload    = (quantum_length == 8'd0) ? 8'd1 : quantum_length;
  assign ticks_dec = ticks_left - {7'd0, (ticks_left != 8'd0)};

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_found = 1'b1;
        free_idx   = TID_W'(i);
      end
    end
  end

  // Work out the command against the current state
  always_comb begin
    slot_busy_next  = slot_busy;
    slot_high_next  = slot_high;
    high_head_next  = high_head;
    high_tail_next  = high_tail;
    high_count_next = high_count;
    low_head_next   = low_head;
    low_tail_next   = low_tail;
    low_count_next  = low_count;
    running_id_next = running_id;
    ticks_left_next = ticks_left;
    finished_next   = finished;
    high_we         = 1'b0;
    low_we          = 1'b0;
    high_wdata      = free_idx;
    low_wdata       = running_id;
    new_id          = '0;
    failed          = 1'b0;
    sw              = 1'b0;
    if (!finished) begin
      case (cmd_q.op)
        tlts_pkg::OP_CREATE: begin
          if (!free_found) begin
            failed = 1'b1;
          end else begin
            slot_busy_next[free_idx] = 1'b1;
            slot_high_next[free_idx] = cmd_q.priority_high;
            new_id                   = free_idx;
            if (cmd_q.priority_high) begin
              if (high_count < CNT_W'(MAX_THREADS)) begin
                high_we         = 1'b1;
                high_wdata      = free_idx;
                high_tail_next  = wrap_inc(high_tail);
                high_count_next = high_count + 1'b1;
              end
            end else if (low_count < CNT_W'(MAX_THREADS)) begin
              low_we         = 1'b1;
              low_wdata      = free_idx;
              low_tail_next  = wrap_inc(low_tail);
              low_count_next = low_count + 1'b1;
            end
          end
        end
        tlts_pkg::OP_TICK: begin
          if (!slot_high[running_id]) begin
            ticks_left_next = ticks_dec;
            if (high_count != '0 || ticks_dec == 8'd0) begin
              ticks_left_next = reload;
              if (high_count != '0) begin
                running_id_next = high_rd;
                high_head_next  = wrap_inc(high_head);
                high_count_next = high_count - 1'b1;
                sw              = 1'b1;
                if (low_count < CNT_W'(MAX_THREADS)) begin
                  low_we         = 1'b1;
                  low_tail_next  = wrap_inc(low_tail);
                  low_count_next = low_count + 1'b1;
                end
              end else if (low_count != '0) begin
                // Rotate: pop the head and push the runner, count stays
                running_id_next = low_rd;
                low_head_next   = wrap_inc(low_head);
                low_we          = 1'b1;
                low_tail_next   = wrap_inc(low_tail);
                sw              = 1'b1;
              end
            end
          end
        end
        tlts_pkg::OP_EXIT: begin
          slot_busy_next[running_id] = 1'b0;
          if (high_count != '0) begin
            running_id_next = high_rd;
            high_head_next  = wrap_inc(high_head);
            high_count_next = high_count - 1'b1;
            ticks_left_next = reload;
            sw              = 1'b1;
          end else if (low_count != '0) begin
            running_id_next = low_rd;
            low_head_next   = wrap_inc(low_head);
            low_count_next  = low_count - 1'b1;
            ticks_left_next = reload;
            sw              = 1'b1;
          end else begin
            finished_next = 1'b1;
          end
        end
        tlts_pkg::OP_SET: begin
          slot_high_next[running_id] = cmd_q.priority_high;
        end
        default: begin
        end
      endcase
    end

    // Report ids masked to the four result bits
    run_ext                  = {4'd0, running_id_next};
    new_ext                  = {4'd0, new_id};
    res_next.running_thread  = run_ext[3:0];
    res_next.running_is_high = slot_high_next[running_id_next];
    res_next.new_thread      = new_ext[3:0];
    res_next.create_failed   = failed;
    res_next.switched        = sw;
    res_next.all_done        = finished_next;
  end

  // Write back queue entries
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && high_we) begin
      high_mem[high_tail] <= high_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && low_we) begin
      low_mem[low_tail] <= low_wdata;
    end
  end

  // Read queue heads every cycle
  always_ff @(posedge clk) begin
    high_rd <= high_mem[high_head];
    low_rd  <= low_mem[low_head];
  end

  // Hold the quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_length <= tlts_pkg::QUANTUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      quantum_length <= cfg_data;
    end
  end

  // Latch the accepted command
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // Sequence commands, commit state and strobe results
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      slot_busy    <= MAX_THREADS'(1);
      slot_high    <= '0;
      high_head    <= '0;
      high_tail    <= '0;
      high_count   <= '0;
      low_head     <= '0;
      low_tail     <= '0;
      low_count    <= '0;
      running_id   <= '0;
      ticks_left   <= tlts_pkg::QUANTUM_RESET;
      finished     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          slot_busy    <= slot_busy_next;
          slot_high    <= slot_high_next;
          high_head    <= high_head_next;
          high_tail    <= high_tail_next;
          high_count   <= high_count_next;
          low_head     <= low_head_next;
          low_tail     <= low_tail_next;
          low_count    <= low_count_next;
          running_id   <= running_id_next;
          ticks_left   <= ticks_left_next;
          finished     <= finished_next;
          result       <= res_next;
          result_valid <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  `TLTS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !result_valid)
  `TLTS_ASSERT_SAME(a_strobe_idle, clk, rst, result_valid, !busy)
  `TLTS_ASSERT_SAME(a_fail_no_id, clk, rst, result_valid && result.create_failed, result.new_thread == 4'd0)
  `TLTS_ASSERT_SAME(a_queue_bound, clk, rst, 1'b1, ({1'b0, high_count} + {1'b0, low_count}) < (CNT_W + 1)'(MAX_THREADS))

endmodule

`default_nettype wire

// ===== tb/two_level_thread_scheduler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_thread_scheduler_test
// Drives create, tick, exit and set-priority commands into the scheduler and
// tracks slots, both ready queues and the quantum alongside it. Every strobed
// result is compared field by field with the tracked outcome. The run passes
// through several quantum settings and sender pacing modes, and it ends by
// exiting every thread until the block reports all done.
// ----------------------------------------------------------------------------

module two_level_thread_scheduler_test;
  import tlts_pkg::*;

  localparam int SLOTS   = MAX_THREADS_DEF;
  localparam int LOW_Q   = 0;
  localparam int HIGH_Q  = 1;
  localparam int REPORTS = 10;

  // Tracks scheduler state and holds the outcomes still owed by the block
  class sched_tracker;
    bit       slot_busy[SLOTS];
    bit       slot_high[SLOTS];
    bit [3:0] fifo[2][SLOTS];
    int       head[2];
    int       tail[2];
    int       count[2];
    int       running;
    int       ticks_left;
    bit       finished;
    bit [7:0] quantum;
    out_t     owed_results[$];
    int       mismatches;
    int       commands;
    int       switches;
    int       refused_creates;

    function new();
      foreach (slot_busy[i]) begin
        slot_busy[i] = 1'b0;
        slot_high[i] = 1'b0;
      end
      slot_busy[0] = 1'b1;
      head       = '{0, 0};
      tail       = '{0, 0};
      count      = '{0, 0};
      running    = 0;
      quantum    = QUANTUM_RESET;
      ticks_left = int'(QUANTUM_RESET);
      finished   = 1'b0;
    endfunction

    function void set_quantum(bit [7:0] value);
      quantum = value;
    endfunction

    // Treat a zero quantum as one tick
    function int reload();
      return (quantum == 0) ? 1 : int'(quantum);
    endfunction

    // Drop the id when the queue is full
    function void push(int q, int id);
      if (count[q] >= SLOTS) return;
      fifo[q][tail[q]] = id[3:0];
      tail[q] = (tail[q] + 1) % SLOTS;
      count[q]++;
    endfunction

    function int pop(int q);
      int id;
      id = int'(fifo[q][head[q]]);
      head[q] = (head[q] + 1) % SLOTS;
      count[q]--;
      return id;
    endfunction

    // Advance the tracked state by one accepted command and owe its outcome
    function void note_command(in_t c);
      out_t outcome;
      int   run;
      int   slot;
      outcome = '0;
      run = running;
      if (!finished) begin
        case (c.op)
          OP_CREATE: begin
            slot = 0;
            while (slot < SLOTS && slot_busy[slot]) slot++;
            if (slot == SLOTS) begin
              outcome.create_failed = 1'b1;
            end else begin
              slot_busy[slot] = 1'b1;
              slot_high[slot] = c.priority_high;
              outcome.new_thread = slot[3:0];
              push(c.priority_high ? HIGH_Q : LOW_Q, slot);
            end
          end
          OP_TICK: begin
            if (!slot_high[run]) begin
              if (ticks_left > 0) ticks_left--;
              if (count[HIGH_Q] > 0 || ticks_left == 0) begin
                ticks_left = reload();
                if (count[HIGH_Q] > 0 || count[LOW_Q] > 0) begin
                  running = pop(count[HIGH_Q] > 0 ? HIGH_Q : LOW_Q);
                  push(LOW_Q, run);
                  outcome.switched = 1'b1;
                end
              end
            end
          end
          OP_EXIT: begin
            slot_busy[run] = 1'b0;
            if (count[HIGH_Q] > 0 || count[LOW_Q] > 0) begin
              running = pop(count[HIGH_Q] > 0 ? HIGH_Q : LOW_Q);
              ticks_left = reload();
              outcome.switched = 1'b1;
            end else begin
              finished = 1'b1;
            end
          end
          default: begin
            slot_high[run] = c.priority_high;
          end
        endcase
      end
      outcome.running_thread  = running[3:0];
      outcome.running_is_high = slot_high[running];
      outcome.all_done        = finished;
      owed_results.push_back(outcome);
      commands++;
      if (outcome.switched) switches++;
      if (outcome.create_failed) refused_creates++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORTS) $display("%0t: %s", $time, what);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want)
        flag($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    // Compare one strobed result with the oldest owed outcome
    function void check_result(out_t got);
      out_t want;
      if (owed_results.size() == 0) begin
        flag($sformatf("result %p arrived with nothing owed", got));
        return;
      end
      want = owed_results.pop_front();
      compare_field("running_thread", want.running_thread, got.running_thread);
      compare_field("running_is_high", 4'(want.running_is_high), 4'(got.running_is_high));
      compare_field("new_thread", want.new_thread, got.new_thread);
      compare_field("create_failed", 4'(want.create_failed), 4'(got.create_failed));
      compare_field("switched", 4'(want.switched), 4'(got.switched));
      compare_field("all_done", 4'(want.all_done), 4'(got.all_done));
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  in_t          cmd;
  logic         result_valid;
  out_t         result;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [7:0]   cfg_data;
  sched_tracker tracker;

  two_level_thread_scheduler uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) tracker.check_result(result);
  end

  // Hold one command until the block takes it; keep start high afterward
  task automatic send_command(logic [1:0] op_code, logic pri);
    @(negedge clk);
    cmd.op = op_code;
    cmd.priority_high = pri;
    start = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_command(cmd);
  endtask

  // Leave the command port idle with noise on the payload
  task automatic idle_cycle();
    @(negedge clk);
    start = 1'b0;
    cmd.op = 2'($urandom_range(3));
    cmd.priority_high = 1'($urandom_range(1));
  endtask

  task automatic drain();
    idle_cycle();
    while (tracker.owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_quantum(logic [7:0] value);
    @(negedge clk);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_quantum(value);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data = 8'($urandom);
  endtask

  // Pick a command that keeps at least one thread alive
  task automatic random_command();
    int         r;
    logic [1:0] op_code;
    r = $urandom_range(99);
    if (r < 25) op_code = OP_CREATE;
    else if (r < 65) op_code = OP_TICK;
    else if (r < 83) op_code = OP_EXIT;
    else op_code = OP_SET;
    if (op_code == OP_EXIT && tracker.count[HIGH_Q] + tracker.count[LOW_Q] == 0)
      op_code = OP_CREATE;
    send_command(op_code, 1'($urandom_range(1)));
  endtask

  task automatic run_phase(logic [7:0] quantum_value, int items, int idle_pct);
    drain();
    write_quantum(quantum_value);
    repeat (items) begin
      while ($urandom_range(99) < idle_pct) idle_cycle();
      random_command();
    end
  endtask

  initial begin
    tracker   = new();
    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero quantum: a lone low thread uses up its ticks, runs out twice and keeps running
    write_quantum(8'd0);
    repeat (11) send_command(OP_TICK, 1'b0);
    // A high running thread ignores ticks
    send_command(OP_SET, 1'b1);
    send_command(OP_TICK, 1'b1);
    send_command(OP_SET, 1'b0);
    // Fill the slot table, then overflow it
    for (int i = 1; i < SLOTS; i++) send_command(OP_CREATE, 1'(i));
    send_command(OP_CREATE, 1'b1);
    // Preempt for a waiting high thread, free a slot and reuse it
    send_command(OP_TICK, 1'b0);
    send_command(OP_EXIT, 1'b0);
    send_command(OP_CREATE, 1'b0);
    send_command(OP_TICK, 1'b1);
    send_command(OP_EXIT, 1'b1);

    // Random traffic under several quanta and pacing modes
    run_phase(8'd255, 240, 0);
    run_phase(8'd1, 240, 80);
    run_phase(8'($urandom_range(2, 30)), 240, 0);
    run_phase(QUANTUM_RESET, 240, 8);

    // Exit every thread, then confirm that commands are ignored
    drain();
    while (!tracker.finished) send_command(OP_EXIT, 1'($urandom_range(1)));
    send_command(OP_CREATE, 1'b1);
    send_command(OP_TICK, 1'b0);
    send_command(OP_EXIT, 1'b0);
    send_command(OP_SET, 1'b1);

    drain();
    repeat (6) @(posedge clk);
    if (tracker.owed_results.size() != 0)
      tracker.flag($sformatf("%0d results never arrived", tracker.owed_results.size()));
    $display("Ran %0d commands across quanta 0 to 255 with %0d thread switches.",
             tracker.commands, tracker.switches);
    $display("Saw %0d refused creates and a full shutdown; %0d mismatches counted.",
             tracker.refused_creates, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== two_level_thread_scheduler.f =====
+incdir+hw/rtl
hw/rtl/tlts_pkg.sv
hw/rtl/two_level_thread_scheduler.sv
tb/two_level_thread_scheduler_test.sv
